/* sv/mie_pkg.sv */
// Shared types, character codes and helper functions for the import name extractor.
package mie_pkg;

  // Comment nesting limit and the counter width it needs
  localparam int MAX_NEST_DEPTH = 255;
  localparam int DEPTH_W = $clog2(MAX_NEST_DEPTH + 1);

  // Results one source byte can cause, and the queue between lexer and serializer
  localparam int RES_MAX = 3;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // Keyword lengths and the saturation point of match progress
  localparam logic [3:0] KW_EXT_LEN = 4'd7;
  localparam logic [3:0] KW_INST_LEN = 4'd8;
  localparam logic [3:0] KW_SAT = 4'd15;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  // Lexer mode, one-hot
  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_BLOCK  = 5'b00010,
    MODE_LINE   = 5'b00100,
    MODE_STRING = 5'b01000,
    MODE_STRESC = 5'b10000
  } mode_t;

  // Held first byte of a possible two-byte mark, one-hot
  typedef enum logic [3:0] {
    LEAD_NONE   = 4'b0001,
    LEAD_PAREN  = 4'b0010,
    LEAD_BSLASH = 4'b0100,
    LEAD_STAR   = 4'b1000
  } lead_t;

  // Import list tracking, one-hot
  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_AFTER_EXT  = 5'b00010,
    PH_LIST_NAME  = 5'b00100,
    PH_LIST_COMMA = 5'b01000,
    PH_AFTER_INST = 5'b10000
  } phase_t;

  // Keyword match progress of the current identifier
  typedef struct packed {
    logic [3:0] progress;
    logic       ext;
    logic       inst;
  } kw_t;

  // All results caused by one source byte
  typedef struct packed {
    logic [1:0]                count;
    kind_t [RES_MAX-1:0]       kind;
    logic [RES_MAX-1:0][7:0]   chr;
  } bundle_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
  endfunction

  function automatic logic [7:0] kw_ext_char(logic [2:0] pos);
    logic [7:0] r;
    unique case (pos)
      3'd0: r = 8'h45;  // E
      3'd1: r = 8'h58;  // X
      3'd2: r = 8'h54;  // T
      3'd3: r = 8'h45;  // E
      3'd4: r = 8'h4E;  // N
      3'd5: r = 8'h44;  // D
      3'd6: r = 8'h53;  // S
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_inst_char(logic [2:0] pos);
    logic [7:0] r;
    unique case (pos)
      3'd0: r = 8'h49;  // I
      3'd1: r = 8'h4E;  // N
      3'd2: r = 8'h53;  // S
      3'd3: r = 8'h54;  // T
      3'd4: r = 8'h41;  // A
      3'd5: r = 8'h4E;  // N
      3'd6: r = 8'h43;  // C
      default: r = 8'h45;  // E
    endcase
    return r;
  endfunction

  // Match one more identifier character against both keywords
  function automatic kw_t kw_feed(kw_t k, logic [7:0] c);
    kw_t r;
    r = k;
    if (k.progress >= KW_EXT_LEN || kw_ext_char(k.progress[2:0]) != c) r.ext = 1'b0;
    if (k.progress >= KW_INST_LEN || kw_inst_char(k.progress[2:0]) != c) r.inst = 1'b0;
    if (k.progress < KW_SAT) r.progress = k.progress + 4'd1;
    return r;
  endfunction

  // Append one result to a bundle, dropping anything past the limit
  function automatic bundle_t push_res(bundle_t b, kind_t k, logic [7:0] c);
    bundle_t r;
    r = b;
    if (b.count < 2'd3) begin
      r.kind[b.count] = k;
      r.chr[b.count] = (k == KIND_CHAR) ? c : 8'h00;
      r.count = b.count + 2'd1;
    end
    return r;
  endfunction

endpackage

/* sv/mie_front.sv */
// Lexer front end: takes one source byte per cycle while the queue has room and builds its result bundle.
module mie_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       ch,
  input  logic             last_char,
  input  mie_pkg::q_stat_t q_stat,
  output logic             q_push,
  output mie_pkg::bundle_t q_data
);
  import mie_pkg::*;

  mode_t              mode, mode_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  lead_t              lead, lead_next;
  phase_t             phase, phase_next;
  kw_t                kw, kw_next;
  logic               name_open, name_open_next;
  bundle_t            bun;
  logic               accept;
  logic               cont;

  // Accept a byte whenever the queue has room
  assign in_ready = !q_stat.full;
  assign accept = in_valid && in_ready;
  assign q_push = accept && (bun.count != 2'd0);
  assign q_data = bun;

  // Next lexer state and results for the current byte
  always_comb begin
    mode_next = mode;
    depth_next = depth;
    lead_next = lead;
    phase_next = phase;
    kw_next = kw;
    name_open_next = name_open;
    bun = '0;
    cont = 1'b0;

    unique case (mode)
      MODE_BLOCK: begin
        lead_next = LEAD_NONE;
        if (lead == LEAD_PAREN && ch == CH_STAR) begin
          if (depth < DEPTH_W'(MAX_NEST_DEPTH)) depth_next = depth + 1'b1;
        end else if (lead == LEAD_STAR && ch == CH_RPAREN) begin
          if (depth != '0) depth_next = depth - 1'b1;
          if (depth_next == '0) mode_next = MODE_NORMAL;
        end else if (ch == CH_LPAREN) begin
          lead_next = LEAD_PAREN;
        end else if (ch == CH_STAR) begin
          lead_next = LEAD_STAR;
        end
      end
      MODE_LINE: begin
        if (ch == CH_NL) mode_next = MODE_NORMAL;
      end
      MODE_STRING: begin
        if (ch == CH_BSLASH) mode_next = MODE_STRESC;
        else if (ch == CH_DQUOTE) mode_next = MODE_NORMAL;
      end
      MODE_STRESC: begin
        mode_next = MODE_STRING;
      end
      default: begin
        lead_next = LEAD_NONE;
        if (lead == LEAD_BSLASH && ch == CH_STAR) begin
          mode_next = MODE_LINE;
        end else if (lead == LEAD_PAREN && ch == CH_STAR) begin
          mode_next = MODE_BLOCK;
          depth_next = DEPTH_W'(1);
        end else begin
          // Continue or close the identifier in progress
          if (name_open || kw.progress != 4'd0) begin
            if (is_ident_char(ch)) begin
              cont = 1'b1;
              if (name_open) bun = push_res(bun, KIND_CHAR, ch);
              else kw_next = kw_feed(kw, ch);
            end else begin
              if (name_open) begin
                bun = push_res(bun, KIND_END, 8'h00);
                name_open_next = 1'b0;
              end else if (kw.ext && kw.progress == KW_EXT_LEN) begin
                phase_next = PH_AFTER_EXT;
              end else if (kw.inst && kw.progress == KW_INST_LEN) begin
                phase_next = PH_AFTER_INST;
              end
              kw_next = '{progress: 4'd0, ext: 1'b1, inst: 1'b1};
            end
          end
          // Classify a byte that starts something new
          if (!cont) begin
            if (ch == CH_BSLASH) begin
              lead_next = LEAD_BSLASH;
            end else if (ch == CH_LPAREN) begin
              lead_next = LEAD_PAREN;
            end else if (ch == CH_DQUOTE) begin
              mode_next = MODE_STRING;
            end else if (ch == CH_COMMA) begin
              if (phase_next == PH_LIST_NAME) begin
                phase_next = PH_LIST_COMMA;
              end else if (phase_next == PH_AFTER_INST) begin
                bun = push_res(bun, KIND_CHAR, CH_COMMA);
                bun = push_res(bun, KIND_END, 8'h00);
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_IDLE;
              end
            end else if (is_alpha(ch) || ch == CH_UNDER) begin
              if (phase_next == PH_AFTER_EXT || phase_next == PH_LIST_COMMA) begin
                name_open_next = 1'b1;
                phase_next = PH_LIST_NAME;
                bun = push_res(bun, KIND_CHAR, ch);
              end else if (phase_next == PH_AFTER_INST) begin
                name_open_next = 1'b1;
                phase_next = PH_IDLE;
                bun = push_res(bun, KIND_CHAR, ch);
              end else begin
                phase_next = PH_IDLE;
                kw_next = kw_feed('{progress: 4'd0, ext: 1'b1, inst: 1'b1}, ch);
              end
            end
          end
        end
      end
    endcase

    // Close out the source and return to reset
    if (last_char) begin
      if (name_open_next) bun = push_res(bun, KIND_END, 8'h00);
      bun = push_res(bun, KIND_DONE, 8'h00);
      mode_next = MODE_NORMAL;
      depth_next = '0;
      lead_next = LEAD_NONE;
      phase_next = PH_IDLE;
      kw_next = '{progress: 4'd0, ext: 1'b1, inst: 1'b1};
      name_open_next = 1'b0;
    end
  end

  // Advance lexer state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      depth <= '0;
      lead <= LEAD_NONE;
      phase <= PH_IDLE;
      kw <= '{progress: 4'd0, ext: 1'b1, inst: 1'b1};
      name_open <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      depth <= depth_next;
      lead <= lead_next;
      phase <= phase_next;
      kw <= kw_next;
      name_open <= name_open_next;
    end
  end

endmodule

/* sv/mie_queue.sv */
// Short bundle queue between the lexer and the result serializer.
module mie_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mie_pkg::bundle_t push_data,
  input  logic             pop,
  output mie_pkg::bundle_t head,
  output mie_pkg::q_stat_t stat
);
  import mie_pkg::*;

  bundle_t            mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign head = mem[rd_ptr];
  assign stat.full = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

  // Store pushed bundles
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* sv/mie_back.sv */
// Result serializer: hands out the words of each bundle one per cycle while the output is taken.
module mie_back (
  input  logic                clk,
  input  logic                rst,
  input  mie_pkg::bundle_t    head,
  input  mie_pkg::q_stat_t    q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [7:0]          name_char,
  output logic                last_of_run
);
  import mie_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  // Load the output register when it is free or being taken
  assign load = !q_stat.empty && (!out_valid || out_ready);
  assign is_last = (idx == head.count - 2'd1);
  assign pop = load && is_last;

  // Walk the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the outgoing word
  always_ff @(posedge clk) begin
    if (load) begin
      kind <= head.kind[idx];
      name_char <= head.chr[idx];
      last_of_run <= is_last;
    end
  end

endmodule

/* sv/module_import_name_extractor_unit.sv */
// Import name extractor top level: lexer front end, bundle queue, result serializer.
// Takes one source byte per cycle while the queue has room; the lexer updates its state in the same cycle.
// The first word of a byte's results passes through the bundle queue and then the output register.
// A byte causes up to three words; the serializer sends one word per cycle while the output is taken.
// Synchronous reset returns the lexer to normal text and empties queue and output.
module module_import_name_extractor_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] name_char,
  output logic       last_of_run
);
  import mie_pkg::*;

  q_stat_t q_stat;
  bundle_t q_data;
  bundle_t q_head;
  logic    q_push;
  logic    q_pop;

  mie_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .last_char(last_char),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  mie_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  mie_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .name_char  (name_char),
    .last_of_run(last_of_run)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_stat.full)
    else $error("bundle pushed into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_stat.empty)
    else $error("bundle popped from empty queue");

  // Source-finished word always closes its run
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_DONE) |-> last_of_run)
    else $error("source-finished word not last of run");

  // Non-character words carry a zero character
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_CHAR) |-> (name_char == 8'h00))
    else $error("marker word carries a character");

endmodule
